### rtl/sgm_pca_pkg.sv
// Shared types, constants and helpers for the SGM path cost aggregator.
// Used by the top level, the penalty divider and the port checker.
`timescale 1ns / 1ps
`default_nettype none

package sgm_pca_pkg;

	// Disparity range and derived widths
	localparam int MAX_DISP = 128;
	localparam int DISP_W   = $clog2(MAX_DISP);
	localparam int CNT_W    = $clog2(MAX_DISP + 1);
	localparam int ADDR_W   = DISP_W + 1;
	localparam int RAM_DEPTH = 2 ** ADDR_W;

	// Cost widths: stored path cost, min candidate, sum before normalization
	localparam int COST_W = 11;
	localparam int BEST_W = 12;
	localparam int TOT_W  = 13;
	localparam logic [COST_W-1:0] COST_MAX = '1;

	// Field widths
	localparam int MC_W    = 8;
	localparam int PIX_W   = 8;
	localparam int P1_W    = 8;
	localparam int P2_W    = 10;
	localparam int DCFG_W  = 8;
	localparam int SHIFT_W = 3;

	// Configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 10;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SMALL_PEN = 2'd0,
		CFG_LARGE_PEN = 2'd1,
		CFG_DISP_CNT  = 2'd2,
		CFG_SUM_SHIFT = 2'd3
	} cfg_idx_t;

	// Penalty divider: P2 / (|dI| + 1)
	localparam int DVD_W     = P2_W;
	localparam int DVS_W     = PIX_W + 1;
	localparam int DIV_CNT_W = $clog2(DVD_W + 1);

	typedef struct packed {
		logic             start;
		logic [DVD_W-1:0] dividend;
		logic [DVS_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DVD_W-1:0] quotient;
	} div_rsp_t;

	// Item sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD_A,
		ST_RD_B,
		ST_WAIT,
		ST_MIN,
		ST_COMMIT
	} st_t;

	// Disparity count in use: zero acts as one, clamp to the array size
	function automatic logic [CNT_W-1:0] clamp_count(input logic [DCFG_W-1:0] v);
		logic [CNT_W+DCFG_W-1:0] ext;
		ext = (CNT_W+DCFG_W)'(v);
		if (v == '0)
			return CNT_W'(1);
		else if (ext > (CNT_W+DCFG_W)'(MAX_DISP))
			return CNT_W'(MAX_DISP);
		else
			return CNT_W'(v);
	endfunction

endpackage

`default_nettype wire

### rtl/sgm_pca_ram.sv
// Generic simple RAM: one write port, two read ports with registered data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module sgm_pca_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
	output logic      [WIDTH-1:0]         rdata_a,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic      [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read ports with registered data
	always_ff @(posedge clk) begin
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

`default_nettype wire

### rtl/sgm_pca_div.sv
// Restoring divider for the edge-scaled large penalty, one quotient bit per cycle.
// Depends on sgm_pca_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sgm_pca_div (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire sgm_pca_pkg::div_req_t req,
	output sgm_pca_pkg::div_rsp_t      rsp
);
	import sgm_pca_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DVS_W-1:0]     rem_q;
	logic [DVD_W-1:0]     quo_q;
	logic [DVS_W-1:0]     dvs_q;

	logic [DVS_W:0]   trial;
	logic [DVS_W:0]   sub;
	logic             ge;
	logic [DVS_W-1:0] rem_nx;

	// One trial subtraction per step
	always_comb begin
		trial  = {rem_q, quo_q[DVD_W-1]};
		sub    = trial - {1'b0, dvs_q};
		ge     = trial >= {1'b0, dvs_q};
		rem_nx = ge ? sub[DVS_W-1:0] : trial[DVS_W-1:0];
	end

	// Step counter and done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(DVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Remainder and quotient shift register
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= rem_nx;
			quo_q <= {quo_q[DVD_W-2:0], ge};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

`default_nettype wire

### rtl/sgm_path_cost_aggregator.sv
// Top level of the SGM path cost aggregator: sequencer, cost datapath, cost RAM.
// Depends on sgm_pca_pkg, sgm_pca_ram and sgm_pca_div.
//
// Usage:
//   Input channel (in_valid / in_stall) takes one word per disparity of a path
//   pixel, disparities 0..count-1 in order. Output channel (out_valid / out_stall)
//   returns one word per input word: path cost, its shifted sum contribution and
//   a pixel-done flag on the last disparity.
//   Configuration is written through cfg_we / cfg_index / cfg_data while idle.
//   Throughput is one word at a time. A word on the first pixel of a path goes
//   straight from ST_IDLE to ST_COMMIT. Other words pass through ST_RD_A, ST_RD_B,
//   ST_WAIT and ST_MIN when the scaled penalty for their intensity step is already
//   held; otherwise the 10-step penalty divider runs first and ST_WAIT holds until
//   it is done.
//   The next word is taken while a finished result waits in the output register;
//   a word whose result cannot leave holds the block until out_stall drops.
//   Path costs live in a two-bank RAM (previous pixel, current pixel) read at
//   d-1, d and d+1 in states ST_RD_A and ST_RD_B.
//   Reset (arst_n low) loads the register defaults and makes the next pixel a
//   path start. The RAM is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module sgm_path_cost_aggregator (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// configuration write port
	input  wire logic                                cfg_we,
	input  wire logic [sgm_pca_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [sgm_pca_pkg::CFG_DATA_W-1:0]  cfg_data,
	// input channel
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic [sgm_pca_pkg::MC_W-1:0]        match_cost,
	input  wire logic [sgm_pca_pkg::PIX_W-1:0]       pixel_intensity,
	input  wire logic [sgm_pca_pkg::PIX_W-1:0]       neighbor_intensity,
	input  wire logic                                path_start,
	// output channel
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic      [sgm_pca_pkg::COST_W-1:0]      path_cost,
	output logic      [sgm_pca_pkg::COST_W-1:0]      sum_contribution,
	output logic                                     pixel_done
);
	import sgm_pca_pkg::*;

	// Configuration registers
	logic [P1_W-1:0]    p1_q;
	logic [P2_W-1:0]    p2_q;
	logic [DCFG_W-1:0]  dcfg_q;
	logic [SHIFT_W-1:0] shift_q;

	// Path state
	st_t               state_q, state_d;
	logic              bank_q;
	logic [COST_W-1:0] pmin_q;
	logic [COST_W-1:0] rmin_q;
	logic [DISP_W-1:0] dcnt_q;
	logic              pif_q;

	// Current word
	logic [MC_W-1:0]   cost_q;
	logic [PIX_W-1:0]  diff_q;
	logic              first_q;
	logic [COST_W-1:0] lp_mid_q;
	logic [COST_W-1:0] lp_lo_q;
	logic [BEST_W-1:0] best_q;

	// Scaled penalty held for the last intensity step
	logic [DVD_W-1:0] pen_q;
	logic [PIX_W-1:0] pen_diff_q;
	logic             pen_vld_q;

	// Output register
	logic              out_valid_q;
	logic [COST_W-1:0] path_cost_q;
	logic [COST_W-1:0] sum_q;
	logic              done_q;

	logic              accept;
	logic              commit;
	logic              div_start;
	logic              pen_hit;
	logic              item_first;
	logic [PIX_W-1:0]  diff;
	logic [CNT_W-1:0]  count;
	logic              last;
	logic [P2_W-1:0]   p2s;
	logic [BEST_W-1:0] best;
	logic [TOT_W-1:0]  total;
	logic [TOT_W-1:0]  net;
	logic [COST_W-1:0] cost_l;

	logic [ADDR_W-1:0] raddr_a, raddr_b, waddr;
	logic [COST_W-1:0] rdata_a, rdata_b;

	div_req_t div_req;
	div_rsp_t div_rsp;

	// Word-level decode
	always_comb begin
		accept     = in_valid && !in_stall;
		item_first = (dcnt_q == '0) ? (pif_q | path_start) : pif_q;
		diff       = (pixel_intensity > neighbor_intensity) ?
			(pixel_intensity - neighbor_intensity) : (neighbor_intensity - pixel_intensity);
		count      = clamp_count(dcfg_q);
		last       = (CNT_W'(dcnt_q) + CNT_W'(1)) >= count;
		pen_hit    = pen_vld_q && (pen_diff_q == diff_q);
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		div_start = 1'b0;
		commit    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = item_first ? ST_COMMIT : ST_RD_A;
				end
			end
			ST_RD_A: begin
				div_start = !pen_hit;
				state_d   = ST_RD_B;
			end
			ST_RD_B: begin
				state_d = ST_WAIT;
			end
			ST_WAIT: begin
				if (pen_hit) begin
					state_d = ST_MIN;
				end
			end
			ST_MIN: begin
				state_d = ST_COMMIT;
			end
			ST_COMMIT: begin
				if (!out_valid_q || !out_stall) begin
					commit  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign in_stall = (state_q != ST_IDLE);

	// Previous bank reads: d and d-1 first, then d+1 held on port a
	always_comb begin
		raddr_a = (state_q == ST_RD_A) ? {~bank_q, dcnt_q} : {~bank_q, dcnt_q + 1'b1};
		raddr_b = {~bank_q, dcnt_q - 1'b1};
		waddr   = {bank_q, dcnt_q};
	end

	sgm_pca_ram #(
		.WIDTH (COST_W),
		.DEPTH (RAM_DEPTH)
	) u_ram (
		.clk     (clk),
		.we      (commit),
		.waddr   (waddr),
		.wdata   (cost_l),
		.raddr_a (raddr_a),
		.rdata_a (rdata_a),
		.raddr_b (raddr_b),
		.rdata_b (rdata_b)
	);

	// Edge-scaled penalty
	always_comb begin
		div_req.start    = div_start;
		div_req.dividend = p2_q;
		div_req.divisor  = DVS_W'(diff_q) + DVS_W'(1);
	end

	sgm_pca_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Minimum over the four transitions
	always_comb begin
		p2s  = (pen_q < P2_W'(p1_q)) ? P2_W'(p1_q) : pen_q;
		best = BEST_W'(lp_mid_q);
		if (dcnt_q != '0 && (BEST_W'(lp_lo_q) + BEST_W'(p1_q)) < best) begin
			best = BEST_W'(lp_lo_q) + BEST_W'(p1_q);
		end
		if (!last && (BEST_W'(rdata_a) + BEST_W'(p1_q)) < best) begin
			best = BEST_W'(rdata_a) + BEST_W'(p1_q);
		end
		if ((BEST_W'(pmin_q) + BEST_W'(p2s)) < best) begin
			best = BEST_W'(pmin_q) + BEST_W'(p2s);
		end
	end

	// Path cost: normalized by previous minimum, saturated; first pixel raw
	always_comb begin
		total = TOT_W'(cost_q) + TOT_W'(best_q);
		net   = total - TOT_W'(pmin_q);
		if (first_q) begin
			cost_l = COST_W'(cost_q);
		end else if (total < TOT_W'(pmin_q)) begin
			cost_l = '0;
		end else if (net > TOT_W'(COST_MAX)) begin
			cost_l = COST_MAX;
		end else begin
			cost_l = net[COST_W-1:0];
		end
	end

	// Control state, configuration and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p1_q        <= P1_W'(10);
			p2_q        <= P2_W'(150);
			dcfg_q      <= DCFG_W'(64);
			shift_q     <= SHIFT_W'(3);
			bank_q      <= 1'b0;
			pmin_q      <= '0;
			rmin_q      <= COST_MAX;
			dcnt_q      <= '0;
			pif_q       <= 1'b1;
			pen_vld_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx_t'(cfg_index))
					CFG_SMALL_PEN: p1_q    <= cfg_data[P1_W-1:0];
					CFG_LARGE_PEN: begin
						p2_q      <= cfg_data[P2_W-1:0];
						pen_vld_q <= 1'b0;
					end
					CFG_DISP_CNT:  dcfg_q  <= cfg_data[DCFG_W-1:0];
					CFG_SUM_SHIFT: shift_q <= cfg_data[SHIFT_W-1:0];
				endcase
			end
			if (div_rsp.done) begin
				pen_vld_q <= 1'b1;
			end
			if (accept && dcnt_q == '0) begin
				pif_q <= pif_q | path_start;
			end
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (commit) begin
				out_valid_q <= 1'b1;
				if (last) begin
					pmin_q <= (cost_l < rmin_q) ? cost_l : rmin_q;
					rmin_q <= COST_MAX;
					bank_q <= ~bank_q;
					dcnt_q <= '0;
					pif_q  <= 1'b0;
				end else begin
					rmin_q <= (cost_l < rmin_q) ? cost_l : rmin_q;
					dcnt_q <= dcnt_q + 1'b1;
				end
			end
		end
	end

	// Word payload and output word
	always_ff @(posedge clk) begin
		if (accept) begin
			cost_q  <= match_cost;
			diff_q  <= diff;
			first_q <= item_first;
		end
		if (state_q == ST_RD_B) begin
			lp_mid_q <= rdata_a;
			lp_lo_q  <= rdata_b;
		end
		if (state_q == ST_MIN) begin
			best_q <= best;
		end
		if (div_rsp.done) begin
			pen_q      <= div_rsp.quotient;
			pen_diff_q <= diff_q;
		end
		if (commit) begin
			path_cost_q <= cost_l;
			sum_q       <= cost_l >> shift_q;
			done_q      <= last;
		end
	end

	assign out_valid        = out_valid_q;
	assign path_cost        = path_cost_q;
	assign sum_contribution = sum_q;
	assign pixel_done       = done_q;

endmodule

`default_nettype wire

### rtl/sgm_pca_chk.sv
// Port-level checker for the SGM path cost aggregator, bound to the top level.
// Depends on sgm_pca_pkg and sgm_path_cost_aggregator.
`timescale 1ns / 1ps
`default_nettype none

module sgm_pca_chk (
	input wire logic                                clk,
	input wire logic                                arst_n,
	input wire logic                                in_valid,
	input wire logic                                in_stall,
	input wire logic                                out_valid,
	input wire logic                                out_stall,
	input wire logic [sgm_pca_pkg::COST_W-1:0]      path_cost,
	input wire logic [sgm_pca_pkg::COST_W-1:0]      sum_contribution,
	input wire logic                                pixel_done
);
	import sgm_pca_pkg::*;

	// A stalled output word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(path_cost)
			&& $stable(sum_contribution) && $stable(pixel_done))
		else $error("output word changed while stalled");

	// The shifted contribution never exceeds the path cost
	a_sum_le: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> sum_contribution <= path_cost)
		else $error("sum contribution above path cost");

	// One word at a time: busy right after an accept
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second word taken while the first is in flight");

	// A new result only comes out of a word in flight
	a_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared with no word in flight");

endmodule

bind sgm_path_cost_aggregator sgm_pca_chk u_chk (
	.clk              (clk),
	.arst_n           (arst_n),
	.in_valid         (in_valid),
	.in_stall         (in_stall),
	.out_valid        (out_valid),
	.out_stall        (out_stall),
	.path_cost        (path_cost),
	.sum_contribution (sum_contribution),
	.pixel_done       (pixel_done)
);

`default_nettype wire

### verif/sgm_path_cost_aggregator_tb.sv
// Self-checking testbench for sgm_path_cost_aggregator: drives disparity cost words
// through the valid/stall channels and checks every result against a path cost tracker.
// Depends on sgm_pca_pkg and the aggregator RTL only.
`timescale 1ns / 1ps

module sgm_path_cost_aggregator_tb;
	import sgm_pca_pkg::*;

	localparam int unsigned RANDOM_WORDS = 1400;

	// One expected result word
	typedef struct packed {
		logic [COST_W-1:0] cost;
		logic [COST_W-1:0] contrib;
		logic              done;
	} path_result_t;

	// Tracks registers, the two cost banks and the pixel sequencing; holds expected words
	class path_cost_tracker;
		logic [P1_W-1:0]    small_pen;
		logic [P2_W-1:0]    large_pen;
		logic [DCFG_W-1:0]  count_reg;
		logic [SHIFT_W-1:0] shift;
		logic [COST_W-1:0]  bank [2][MAX_DISP];
		bit                 written [2][MAX_DISP];
		bit                 cur_bank;
		int unsigned        prev_min;
		int unsigned        run_min;
		int unsigned        disp_idx;
		bit                 first_pix;
		int unsigned        errors;
		path_result_t       expected_costs[$];

		function new();
			small_pen = 10;
			large_pen = 150;
			count_reg = 64;
			shift = 3;
			cur_bank = 1'b0;
			prev_min = 0;
			run_min = COST_MAX;
			disp_idx = 0;
			first_pix = 1'b1;
			errors = 0;
			foreach (written[b, i]) written[b][i] = 1'b0;
		endfunction

		function void set_reg(cfg_idx_t idx, int unsigned value);
			case (idx)
				CFG_SMALL_PEN: small_pen = P1_W'(value);
				CFG_LARGE_PEN: large_pen = P2_W'(value);
				CFG_DISP_CNT:  count_reg = DCFG_W'(value);
				CFG_SUM_SHIFT: shift = SHIFT_W'(value);
				default: ;
			endcase
		endfunction

		// zero behaves as one, anything above the array size as the array size
		function int unsigned used_count();
			if (count_reg == 0)
				return 1;
			if (count_reg > MAX_DISP)
				return MAX_DISP;
			return count_reg;
		endfunction

		function int unsigned pending();
			return expected_costs.size();
		endfunction

		// Next word opens a pixel that would read previous-bank entries never written
		function bit start_needed();
			int unsigned prv;
			if (disp_idx != 0 || first_pix)
				return 1'b0;
			prv = cur_bank ? 0 : 1;
			for (int i = 0; i < used_count(); i++)
				if (!written[prv][i])
					return 1'b1;
			return 1'b0;
		endfunction

		function void accept_word(logic [MC_W-1:0] mc, logic [PIX_W-1:0] pix,
				logic [PIX_W-1:0] nbr, logic start);
			int unsigned n, prv, step, pen2, best, cand, total, cost;
			path_result_t res;
			n = used_count();
			prv = cur_bank ? 0 : 1;
			// path start only counts on disparity 0
			if (disp_idx == 0)
				first_pix = first_pix | start;
			if (first_pix) begin
				cost = mc;
			end else begin
				step = (pix > nbr) ? pix - nbr : nbr - pix;
				pen2 = large_pen / (step + 1);
				if (pen2 < small_pen)
					pen2 = small_pen;
				best = bank[prv][disp_idx];
				if (disp_idx > 0) begin
					cand = bank[prv][disp_idx - 1];
					cand += small_pen;
					if (cand < best)
						best = cand;
				end
				if (disp_idx + 1 < n) begin
					cand = bank[prv][disp_idx + 1];
					cand += small_pen;
					if (cand < best)
						best = cand;
				end
				cand = prev_min + pen2;
				if (cand < best)
					best = cand;
				total = mc + best;
				// stale costs under the old minimum clamp at zero
				if (total < prev_min) begin
					cost = 0;
				end else begin
					cost = total - prev_min;
					if (cost > COST_MAX)
						cost = COST_MAX;
				end
			end
			bank[cur_bank][disp_idx] = COST_W'(cost);
			written[cur_bank][disp_idx] = 1'b1;
			if (cost < run_min)
				run_min = cost;
			res.cost = COST_W'(cost);
			res.contrib = COST_W'(cost >> shift);
			res.done = (disp_idx + 1 >= n);
			// pixel boundary: swap banks, latch the minimum
			if (res.done) begin
				prev_min = run_min;
				run_min = COST_MAX;
				cur_bank = !cur_bank;
				disp_idx = 0;
				first_pix = 1'b0;
			end else begin
				disp_idx++;
			end
			expected_costs.push_back(res);
		endfunction

		function void check_word(logic [COST_W-1:0] cost, logic [COST_W-1:0] contrib,
				logic done);
			path_result_t exp_r;
			if (expected_costs.size() == 0) begin
				$display("%0t: unexpected result word, expected none, actual path_cost %0d",
					$time, cost);
				errors++;
				return;
			end
			exp_r = expected_costs.pop_front();
			if (cost !== exp_r.cost) begin
				$display("%0t: path_cost mismatch, expected %0d, actual %0d",
					$time, exp_r.cost, cost);
				errors++;
			end
			if (contrib !== exp_r.contrib) begin
				$display("%0t: sum_contribution mismatch, expected %0d, actual %0d",
					$time, exp_r.contrib, contrib);
				errors++;
			end
			if (done !== exp_r.done) begin
				$display("%0t: pixel_done mismatch, expected %0d, actual %0d",
					$time, exp_r.done, done);
				errors++;
			end
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	cfg_idx_t              cfg_index = CFG_SMALL_PEN;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [MC_W-1:0]       match_cost = '0;
	logic [PIX_W-1:0]      pixel_intensity = '0;
	logic [PIX_W-1:0]      neighbor_intensity = '0;
	logic                  path_start = 1'b0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [COST_W-1:0]     path_cost;
	logic [COST_W-1:0]     sum_contribution;
	logic                  pixel_done;

	path_cost_tracker tracker;
	int unsigned      words_sent = 0;
	int unsigned      in_quiet = 0;
	int unsigned      out_quiet = 0;

	sgm_path_cost_aggregator u_dut (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Idle cycles before a word; now and then a run of back-to-back words
	function automatic int unsigned pick_gap(inout int unsigned quiet);
		if (quiet > 0) begin
			quiet--;
			return 0;
		end
		if ($urandom_range(0, 29) == 0) begin
			quiet = $urandom_range(10, 40);
			return 0;
		end
		if ($urandom_range(0, 1) == 0)
			return 0;
		return $urandom_range(1, 13);
	endfunction

	function automatic logic [MC_W-1:0] pick_cost();
		case ($urandom_range(0, 7))
			0: return MC_W'(0);
			1: return MC_W'(255);
			2: return MC_W'($urandom_range(0, 15));
			default: return MC_W'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic logic [PIX_W-1:0] pick_gray();
		case ($urandom_range(0, 5))
			0: return PIX_W'(0);
			1: return PIX_W'(255);
			default: return PIX_W'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic int unsigned pick_small_pen();
		case ($urandom_range(0, 5))
			0: return 0;
			1: return 255;
			2: return $urandom_range(0, 255);
			default: return $urandom_range(1, 30);
		endcase
	endfunction

	function automatic int unsigned pick_large_pen();
		case ($urandom_range(0, 5))
			0: return 0;
			1: return 1023;
			2: return $urandom_range(0, 1023);
			default: return $urandom_range(20, 400);
		endcase
	endfunction

	// Mid pixel the count may not rise, so no unwritten entry gets read
	function automatic int unsigned pick_count(bit mid);
		if (mid)
			return $urandom_range(0, tracker.used_count());
		case ($urandom_range(0, 15))
			11: return 0;
			12: return $urandom_range(9, 32);
			13: return MAX_DISP;
			14: return $urandom_range(MAX_DISP + 1, 255);
			15: return $urandom_range(33, MAX_DISP - 1);
			default: return $urandom_range(1, 8);
		endcase
	endfunction

	task automatic write_reg(cfg_idx_t idx, int unsigned value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_DATA_W'(value);
		tracker.set_reg(idx, value);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Drive one cost word and wait for it to be taken
	task automatic send_word(logic [MC_W-1:0] mc, logic [PIX_W-1:0] pix,
			logic [PIX_W-1:0] nbr, logic start);
		int unsigned gap;
		gap = pick_gap(in_quiet);
		if (tracker.start_needed())
			start = 1'b1;
		repeat (gap) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		match_cost <= mc;
		pixel_intensity <= pix;
		neighbor_intensity <= nbr;
		path_start <= start;
		do @(posedge clk); while (in_stall !== 1'b0);
		tracker.accept_word(mc, pix, nbr, start);
		words_sent++;
	endtask

	// Drop valid and wait for every expected word to come back
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (tracker.pending() != 0)
			@(posedge clk);
	endtask

	// One pixel, or its first words up to the limit
	task automatic send_pixel(int unsigned limit);
		logic [PIX_W-1:0] pix, nbr;
		logic             start;
		int unsigned      sent;
		pix = pick_gray();
		nbr = ($urandom_range(0, 2) == 0) ? pix : pick_gray();
		start = ($urandom_range(0, 7) == 0);
		sent = 0;
		do begin
			if ($urandom_range(0, 9) == 0) begin
				pix = pick_gray();
				nbr = pick_gray();
			end
			send_word(pick_cost(), pix, nbr, start);
			start = ($urandom_range(0, 1) == 1);
			sent++;
		end while (tracker.disp_idx != 0 && sent < limit);
	endtask

	task automatic directed_words();
		write_reg(CFG_SMALL_PEN, 10);
		write_reg(CFG_LARGE_PEN, 1023);
		write_reg(CFG_DISP_CNT, 3);
		write_reg(CFG_SUM_SHIFT, 0);
		// first pixel after reset starts a path with path_start low
		send_word(255, 0, 255, 0);
		send_word(0, 0, 255, 0);
		send_word(128, 0, 255, 0);
		// largest intensity step
		send_word(0, 255, 0, 0);
		send_word(255, 255, 0, 0);
		send_word(0, 255, 0, 0);
		// flat intensity; path_start in mid pixel is ignored
		send_word(255, 100, 100, 0);
		send_word(255, 100, 100, 1);
		send_word(255, 100, 100, 0);
		// new path
		send_word(7, 60, 61, 1);
		send_word(0, 60, 61, 0);
		send_word(255, 60, 61, 1);
		// pixel left open after two disparities
		send_word(30, 5, 9, 0);
		send_word(200, 5, 9, 0);
		drain();
		// count lowered below the open disparity: pixel ends on the next word
		write_reg(CFG_DISP_CNT, 1);
		write_reg(CFG_SMALL_PEN, 0);
		write_reg(CFG_LARGE_PEN, 0);
		write_reg(CFG_SUM_SHIFT, 7);
		send_word(255, 5, 9, 0);
		send_word(255, 255, 255, 0);
		send_word(0, 0, 0, 0);
		drain();
		// zero count behaves as one
		write_reg(CFG_DISP_CNT, 0);
		write_reg(CFG_SMALL_PEN, 255);
		write_reg(CFG_LARGE_PEN, 1023);
		send_word(255, 0, 128, 0);
		send_word(1, 128, 0, 0);
		drain();
	endtask

	// New settings, a batch of pixels, sometimes a pixel left open
	task automatic random_phase(bit write_all);
		int unsigned n, pixels;
		bit          mid;
		drain();
		mid = (tracker.disp_idx != 0);
		if (write_all || $urandom_range(0, 1))
			write_reg(CFG_SMALL_PEN, pick_small_pen());
		if (write_all || $urandom_range(0, 1))
			write_reg(CFG_LARGE_PEN, pick_large_pen());
		if (write_all || $urandom_range(0, 1))
			write_reg(CFG_DISP_CNT, pick_count(mid));
		if (write_all || $urandom_range(0, 1))
			write_reg(CFG_SUM_SHIFT, $urandom_range(0, 7));
		n = tracker.used_count();
		pixels = ($urandom_range(30, 120) + n - 1) / n;
		repeat (pixels)
			send_pixel(MAX_DISP + 1);
		if (n > 1 && $urandom_range(0, 3) == 0)
			send_pixel($urandom_range(1, n - 1));
	endtask

	// Result side: random stall, check each word taken
	initial begin : result_sink
		int unsigned hold;
		wait (arst_n === 1'b1);
		forever begin
			hold = pick_gap(out_quiet);
			@(negedge clk);
			while (hold > 0) begin
				out_stall <= 1'b1;
				@(negedge clk);
				hold--;
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (out_valid !== 1'b1);
			tracker.check_word(path_cost, sum_contribution, pixel_done);
		end
	end

	initial begin : stimulus
		int unsigned random_target;
		bit          first_phase;
		tracker = new();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		directed_words();
		random_target = words_sent + RANDOM_WORDS;
		first_phase = 1'b1;
		while (words_sent < random_target) begin
			random_phase(first_phase);
			first_phase = 1'b0;
		end
		drain();
		repeat (20) @(posedge clk);
		if (tracker.errors == 0 && tracker.pending() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// Hang guard
	initial begin : watchdog
		#10_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
